@@ rtl/dba_pkg.sv @@
// Shared constants and control types for the dual bitmap allocator.
package dba_pkg;

    localparam int MAP_BITS_DEF = 4096;
    localparam int WORD_BITS    = 32;
    localparam int INDEX_LIMIT  = 4096;
    localparam int MODE_W       = 2;
    localparam int INDEX_W      = 12;

    localparam logic [MODE_W-1:0] MODE_USE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;

    typedef struct packed {
        logic clr;        // zero one word of both maps at the counter
        logic capture;    // take the input transfer
        logic rd_idx;     // read the word that holds the marked index
        logic scan_issue; // read the next word of the scan
        logic wr_mod;     // write back the marked word
        logic res_ok;     // pending result: index 0, status ok
        logic res_scan;   // pending result from the evaluated scan word
        logic load_out;   // move pending result to the output register
    } cmd_t;

    typedef struct packed {
        logic              cnt_last;
        logic              eval_valid;
        logic              hit;
        logic              eval_last;
        logic [MODE_W-1:0] mode;
    } sts_t;

endpackage

@@ rtl/dba_ctrl.sv @@
// Controller state machine of the dual bitmap allocator.
module dba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  dba_pkg::sts_t sts,
    output dba_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_MWR  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLR: begin
                cmd.clr = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                case (sts.mode)
                    dba_pkg::MODE_USE, dba_pkg::MODE_FREE: begin
                        cmd.rd_idx = 1'b1;
                        state_next = ST_MWR;
                    end
                    dba_pkg::MODE_FIND: begin
                        state_next = ST_SCAN;
                    end
                    default: begin
                        cmd.res_ok = 1'b1;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.eval_valid && (sts.hit || sts.eval_last)) begin
                    cmd.res_scan = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_MWR: begin
                cmd.wr_mod = 1'b1;
                cmd.res_ok = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the previous result has been taken
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLR |=> state_reg != ST_CLR)
        else $error("clearing pass re-entered without reset");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while still held");

endmodule

@@ rtl/dba_dp.sv @@
// Datapath of the dual bitmap allocator: map memories, scan counter and results.
module dba_dp #(
    parameter int MAP_BITS = dba_pkg::MAP_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [dba_pkg::MODE_W-1:0]  in_mode,
    input  logic                        in_which_map,
    input  logic [dba_pkg::INDEX_W-1:0] in_index,
    input  dba_pkg::cmd_t               cmd,
    output dba_pkg::sts_t               sts,
    output logic [dba_pkg::INDEX_W-1:0] out_free_index,
    output logic                        out_status
);

    localparam int WB         = dba_pkg::WORD_BITS;
    localparam int WORDS      = (MAP_BITS + WB - 1) / WB;
    localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIMIT      = (MAP_BITS < dba_pkg::INDEX_LIMIT) ? MAP_BITS
                                                                   : dba_pkg::INDEX_LIMIT;
    localparam int SCAN_WORDS = (LIMIT + WB - 1) / WB;
    localparam int LAST_BITS  = LIMIT - WB * (SCAN_WORDS - 1);
    localparam logic [WB-1:0] PAD_MASK = WB'(~((64'd1 << LAST_BITS) - 64'd1));
    localparam logic [WAW-1:0] CNT_LAST  = WAW'(WORDS - 1);
    localparam logic [WAW-1:0] SCAN_LAST = WAW'(SCAN_WORDS - 1);

    logic [WB-1:0] mem_a [WORDS];
    logic [WB-1:0] mem_b [WORDS];

    logic [dba_pkg::MODE_W-1:0]  mode_reg;
    logic                        map_reg;
    logic [dba_pkg::INDEX_W-1:0] index_reg;
    logic [WAW-1:0]              cnt_reg;
    logic                        cnt_done_reg;
    logic                        rd_vld_reg;
    logic [WAW-1:0]              rd_word_reg;
    logic [WB-1:0]               rdata_reg;
    logic [dba_pkg::INDEX_W-1:0] res_index_reg;
    logic                        res_status_reg;
    logic [dba_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_status_reg;

    logic           in_range;
    logic [WAW-1:0] idx_word;
    logic           scan_rd;
    logic           rd_en;
    logic [WAW-1:0] raddr;
    logic [WB-1:0]  bit_mask;
    logic [WB-1:0]  wdata;
    logic [WB-1:0]  eval_word;
    logic [4:0]     enc;
    logic           hit;

    assign in_range = 32'(index_reg) < 32'(MAP_BITS);
    assign idx_word = WAW'(index_reg >> 5);
    assign scan_rd  = cmd.scan_issue && !cnt_done_reg;
    assign rd_en    = scan_rd || (cmd.rd_idx && in_range);
    assign raddr    = cmd.rd_idx ? idx_word : cnt_reg;
    assign bit_mask = WB'(1) << index_reg[4:0];
    assign wdata    = (mode_reg == dba_pkg::MODE_USE) ? (rdata_reg | bit_mask)
                                                      : (rdata_reg & ~bit_mask);

    // bits past the search limit count as used
    assign eval_word = rdata_reg | ((rd_word_reg == SCAN_LAST) ? PAD_MASK : '0);
    assign hit       = ~&eval_word;

    always_comb begin
        enc = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (!eval_word[i]) begin
                enc = 5'(i);
            end
        end
    end

    assign sts.cnt_last   = (cnt_reg == CNT_LAST);
    assign sts.eval_valid = rd_vld_reg;
    assign sts.hit        = hit;
    assign sts.eval_last  = (rd_word_reg == SCAN_LAST);
    assign sts.mode       = mode_reg;

    assign out_free_index = out_index_reg;
    assign out_status     = out_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem_a[cnt_reg] <= '0;
            mem_b[cnt_reg] <= '0;
        end else if (cmd.wr_mod && in_range) begin
            if (map_reg) begin
                mem_b[idx_word] <= wdata;
            end else begin
                mem_a[idx_word] <= wdata;
            end
        end
        if (rd_en) begin
            rdata_reg <= map_reg ? mem_b[raddr] : mem_a[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            cnt_done_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= scan_rd;
            if (cmd.clr) begin
                cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            end else if (cmd.capture) begin
                cnt_reg      <= '0;
                cnt_done_reg <= 1'b0;
            end else if (scan_rd) begin
                if (cnt_reg == SCAN_LAST) begin
                    cnt_done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            map_reg   <= in_which_map;
            index_reg <= in_index;
        end
        if (scan_rd) begin
            rd_word_reg <= cnt_reg;
        end
        if (cmd.res_ok) begin
            res_index_reg  <= '0;
            res_status_reg <= 1'b0;
        end else if (cmd.res_scan) begin
            res_index_reg  <= hit ? dba_pkg::INDEX_W'((32'(rd_word_reg) << 5) | 32'(enc))
                                  : '0;
            res_status_reg <= !hit;
        end
        if (cmd.load_out) begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

    a_scan_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_scan |-> rd_vld_reg)
        else $error("scan result taken from a word that was not read");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_scan && !hit |=> res_status_reg && res_index_reg == '0)
        else $error("full map must report index zero with full status");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) < 32'(WORDS))
        else $error("word counter past the end of the map");

endmodule

@@ rtl/dual_bitmap_allocator_top.sv @@
// Top level of the dual bitmap allocator.
//
// Keeps an inode bitmap and a block bitmap. Each transfer on the s_ channel
// marks one bit used, marks one bit free, or finds the lowest clear bit of the
// chosen map; every input transfer gives exactly one m_ transfer.
// After reset both maps are cleared one 32-bit word a cycle, (MAP_BITS+31)/32
// words (128 at the default size); s_tready stays low then.
// Items are handled one at a time and s_tready rises again in the same cycle
// as the result is loaded into the output register. A mark goes through a
// read, modify and write of one memory word before its result is loaded, and
// the next mark is accepted only after that; an unused mode goes straight to
// its result. A find reads the words in order from word 0 and stops at the
// first word with a clear bit or at the last word: one word is read and checked per cycle.
// A mark outside the map, an unused mode and a find all leave the map as is;
// a find on a full map returns index 0 with the full flag set.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds the next result until m_tready takes the first.
module dual_bitmap_allocator_top #(
    parameter int MAP_BITS = dba_pkg::MAP_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] index, [15:12] zero
    input  logic [2:0]  s_tuser,   // [1:0] mode, [2] which_map
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] free_index, [15:12] zero
    output logic        m_tuser    // [0] status
);

    dba_pkg::cmd_t               cmd;
    dba_pkg::sts_t               sts;
    logic [dba_pkg::INDEX_W-1:0] free_index;

    dba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dba_dp #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_mode        (s_tuser[1:0]),
        .in_which_map   (s_tuser[2]),
        .in_index       (s_tdata[11:0]),
        .cmd            (cmd),
        .sts            (sts),
        .out_free_index (free_index),
        .out_status     (m_tuser)
    );

    assign m_tdata = {4'd0, free_index};

endmodule
